[sv/emx_pkg.sv]
// Shared types, codes and constants of the ElGamal modular exponentiation engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package emx_pkg;

	// Value width of the modulus, operands and results.
	localparam int W  = 16;
	// Width of a full product of two values.
	localparam int DW = 2 * W;
	// Width of the signed Bezout coefficients (magnitude up to the modulus).
	localparam int TW = W + 2;

	localparam logic [W-1:0] MODULUS_RST     = W'(9979);
	localparam logic [W-1:0] GENERATOR_RST   = W'(2);
	localparam logic [W-1:0] PRIVATE_KEY_RST = W'(1);

	// Configuration register indexes.
	localparam logic [1:0] REG_MODULUS     = 2'd0;
	localparam logic [1:0] REG_GENERATOR   = 2'd1;
	localparam logic [1:0] REG_PRIVATE_KEY = 2'd2;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef struct packed {
		logic         op;
		logic [W-1:0] message;
		logic [W-1:0] ephemeral_exponent;
		logic [W-1:0] cipher_first;
		logic [W-1:0] cipher_second;
	} item_t;

	typedef struct packed {
		logic [W-1:0] out_first;
		logic [W-1:0] out_second;
		logic [W-1:0] recovered;
		logic         status;
	} result_t;

	typedef struct packed {
		logic [W-1:0] modulus;
		logic [W-1:0] generator;
		logic [W-1:0] private_key;
	} cfg_t;

	// Datapath operations.
	localparam logic [3:0] DP_NONE  = 4'd0;
	localparam logic [3:0] DP_LOAD  = 4'd1;
	localparam logic [3:0] DP_PINIT = 4'd2;
	localparam logic [3:0] DP_MUL   = 4'd3;
	localparam logic [3:0] DP_WB    = 4'd4;
	localparam logic [3:0] DP_SHIFT = 4'd5;
	localparam logic [3:0] DP_EINIT = 4'd6;
	localparam logic [3:0] DP_EDIV  = 4'd7;
	localparam logic [3:0] DP_EMUL  = 4'd8;
	localparam logic [3:0] DP_EUPD  = 4'd9;
	localparam logic [3:0] DP_FAIL  = 4'd10;

	// Power setup selects: base and exponent sources.
	localparam logic [2:0] PI_GEN_KEY = 3'd0;
	localparam logic [2:0] PI_ACC_EPH = 3'd1;
	localparam logic [2:0] PI_GEN_EPH = 3'd2;
	localparam logic [2:0] PI_INV_KEY = 3'd3;

	// Multiply selects.
	localparam logic [2:0] MU_ACC_BASE = 3'd0;
	localparam logic [2:0] MU_BASE_SQ  = 3'd1;
	localparam logic [2:0] MU_MSG_ACC  = 3'd2;
	localparam logic [2:0] MU_C1_ONE   = 3'd3;
	localparam logic [2:0] MU_C2_ACC   = 3'd4;

	// Write-back destinations of a reduced product.
	localparam logic [2:0] WB_ACC  = 3'd0;
	localparam logic [2:0] WB_BASE = 3'd1;
	localparam logic [2:0] WB_O2   = 3'd2;
	localparam logic [2:0] WB_A    = 3'd3;
	localparam logic [2:0] WB_REC  = 3'd4;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] sel;
	} dp_cmd_t;

	typedef struct packed {
		logic op;
		logic expo_zero;
		logic expo_lsb;
		logic div_done;
		logic r1_zero;
		logic r0_one;
		logic p_lt2;
	} dp_stat_t;

endpackage
`default_nettype wire

[sv/emx_div.sv]
// Iterative restoring divider: double-width dividend by a single-width divisor,
// four quotient bits per cycle. Depends on emx_pkg.
`default_nettype none
module emx_div import emx_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] num,
	input  wire logic [W-1:0]  den,
	output logic      [DW-1:0] quo,
	output logic      [W-1:0]  rem,
	output logic               done
);
	localparam int STEPS = 4;
	localparam int CYC   = DW / STEPS;
	localparam int CW    = $clog2(CYC);

	logic [DW-1:0] quo_q, quo_d;
	logic [W-1:0]  rem_q, rem_d, den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q, done_q;

	always_comb begin
		logic [W:0] t;
		logic       ge;
		quo_d = quo_q;
		rem_d = rem_q;
		for (int k = 0; k < STEPS; k++) begin
			t     = {rem_d, quo_d[DW-1]};
			ge    = (t >= {1'b0, den_q});
			quo_d = {quo_d[DW-2:0], ge};
			rem_d = ge ? W'(t - {1'b0, den_q}) : t[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(CYC - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule
`default_nettype wire

[sv/emx_dp.sv]
// Datapath: operand registers, modular multiply through the shared divider,
// and the extended Euclid registers. Depends on emx_pkg and emx_div.
`default_nettype none
module emx_dp import emx_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire dp_cmd_t  cmd,
	input  wire cfg_t     cfg,
	input  wire item_t    item,
	output dp_stat_t      stat,
	output result_t       res
);
	item_t               item_q;
	logic [W-1:0]        p_q, acc_q, base_q, expo_q, o2_q, rec_q, r0_q, r1_q;
	logic                st_q;
	logic signed [TW-1:0] t0_q, t1_q, qt_q;

	logic [W-1:0]  ma, mb, inv;
	logic [DW-1:0] prod, div_num, div_quo;
	logic [W-1:0]  div_den, div_rem;
	logic          div_start, div_done;
	logic signed [TW-1:0]  inv_s;
	logic signed [TW+W:0]  qt_full;

	always_comb begin
		case (cmd.sel)
			MU_ACC_BASE: begin ma = acc_q;               mb = base_q; end
			MU_BASE_SQ:  begin ma = base_q;              mb = base_q; end
			MU_MSG_ACC:  begin ma = item_q.message;      mb = acc_q;  end
			MU_C1_ONE:   begin ma = item_q.cipher_first; mb = W'(1);  end
			MU_C2_ACC:   begin ma = item_q.cipher_second; mb = acc_q; end
			default:     begin ma = '0;                  mb = '0;     end
		endcase
	end

	assign prod      = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
	assign div_start = (cmd.op == DP_MUL) || (cmd.op == DP_EDIV);
	assign div_num   = (cmd.op == DP_MUL) ? prod : {{W{1'b0}}, r0_q};
	assign div_den   = (cmd.op == DP_MUL) ? p_q : r1_q;

	emx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.rem    (div_rem),
		.done   (div_done)
	);

	// A negative coefficient is brought into range by one add of the modulus.
	assign inv_s   = t0_q[TW-1] ? t0_q + $signed({2'b00, p_q}) : t0_q;
	assign inv     = inv_s[W-1:0];
	assign qt_full = $signed({1'b0, div_quo[W-1:0]}) * t1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= 1'b0;
		end else if (cmd.op == DP_LOAD) begin
			st_q <= 1'b0;
		end else if (cmd.op == DP_FAIL) begin
			st_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD: begin
				item_q <= item;
				p_q    <= (cfg.modulus < W'(2)) ? W'(1) : cfg.modulus;
				o2_q   <= '0;
				rec_q  <= '0;
			end
			DP_PINIT: begin
				acc_q <= (p_q == W'(1)) ? W'(0) : W'(1);
				case (cmd.sel)
					PI_GEN_KEY: begin base_q <= cfg.generator; expo_q <= cfg.private_key; end
					PI_ACC_EPH: begin base_q <= acc_q; expo_q <= item_q.ephemeral_exponent; end
					PI_GEN_EPH: begin
						base_q <= cfg.generator;
						expo_q <= item_q.ephemeral_exponent;
					end
					default:    begin base_q <= inv; expo_q <= cfg.private_key; end
				endcase
			end
			DP_WB: begin
				case (cmd.sel)
					WB_ACC:  acc_q  <= div_rem;
					WB_BASE: base_q <= div_rem;
					WB_O2:   o2_q   <= div_rem;
					WB_A:    r1_q   <= div_rem;
					WB_REC:  rec_q  <= div_rem;
					default: ;
				endcase
			end
			DP_SHIFT: expo_q <= expo_q >> 1;
			DP_EINIT: begin
				r0_q <= p_q;
				t0_q <= '0;
				t1_q <= TW'(1);
			end
			DP_EMUL: qt_q <= qt_full[TW-1:0];
			DP_EUPD: begin
				r0_q <= r1_q;
				r1_q <= div_rem;
				t0_q <= t1_q;
				t1_q <= t0_q - qt_q;
			end
			DP_NONE, DP_MUL, DP_EDIV, DP_FAIL: ;
			default: ;
		endcase
	end

	assign stat.op        = item_q.op;
	assign stat.expo_zero = (expo_q == '0);
	assign stat.expo_lsb  = expo_q[0];
	assign stat.div_done  = div_done;
	assign stat.r1_zero   = (r1_q == '0);
	assign stat.r0_one    = (r0_q == W'(1));
	assign stat.p_lt2     = (p_q < W'(2));

	assign res.out_first  = (item_q.op == OP_DECRYPT) ? '0 : acc_q;
	assign res.out_second = (item_q.op == OP_DECRYPT) ? '0 : o2_q;
	assign res.recovered  = rec_q;
	assign res.status     = st_q;
endmodule
`default_nettype wire

[sv/emx_ctrl.sv]
// Controller state machine: sequences the exponentiations, the reductions and
// the extended Euclid loop on the datapath. Depends on emx_pkg.
`default_nettype none
module emx_ctrl import emx_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy,
	output logic          done
);
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_PINIT = 5'd2;
	localparam logic [4:0] S_PCHK  = 5'd3;
	localparam logic [4:0] S_PMUL  = 5'd4;
	localparam logic [4:0] S_PMW   = 5'd5;
	localparam logic [4:0] S_PSQR  = 5'd6;
	localparam logic [4:0] S_PSW   = 5'd7;
	localparam logic [4:0] S_PSHF  = 5'd8;
	localparam logic [4:0] S_XMUL  = 5'd9;
	localparam logic [4:0] S_XW    = 5'd10;
	localparam logic [4:0] S_EINIT = 5'd11;
	localparam logic [4:0] S_ECHK  = 5'd12;
	localparam logic [4:0] S_EDIV  = 5'd13;
	localparam logic [4:0] S_EDW   = 5'd14;
	localparam logic [4:0] S_EMUL  = 5'd15;
	localparam logic [4:0] S_EUPD  = 5'd16;
	localparam logic [4:0] S_DONE  = 5'd17;

	// Phases of an operation.
	localparam logic [2:0] PH_Y   = 3'd0;
	localparam logic [2:0] PH_T   = 3'd1;
	localparam logic [2:0] PH_O2  = 3'd2;
	localparam logic [2:0] PH_O1  = 3'd3;
	localparam logic [2:0] PH_RED = 3'd4;
	localparam logic [2:0] PH_INV = 3'd5;
	localparam logic [2:0] PH_REC = 3'd6;

	logic [4:0] state_q, state_d;
	logic [2:0] ph_q, ph_d;

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		cmd     = '{op: DP_NONE, sel: 3'd0};
		unique case (state_q)
			S_IDLE: if (start) begin
				cmd.op  = DP_LOAD;
				state_d = S_DISP;
			end
			S_DISP: begin
				if (stat.op == OP_DECRYPT) begin
					ph_d = PH_RED; state_d = S_XMUL;
				end else begin
					ph_d = PH_Y;   state_d = S_PINIT;
				end
			end
			S_PINIT: begin
				cmd.op = DP_PINIT;
				case (ph_q)
					PH_Y:    cmd.sel = PI_GEN_KEY;
					PH_T:    cmd.sel = PI_ACC_EPH;
					PH_O1:   cmd.sel = PI_GEN_EPH;
					default: cmd.sel = PI_INV_KEY;
				endcase
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (stat.expo_zero) begin
					case (ph_q)
						PH_Y:    begin ph_d = PH_T;   state_d = S_PINIT; end
						PH_T:    begin ph_d = PH_O2;  state_d = S_XMUL;  end
						PH_INV:  begin ph_d = PH_REC; state_d = S_XMUL;  end
						default: state_d = S_DONE;
					endcase
				end else begin
					state_d = stat.expo_lsb ? S_PMUL : S_PSQR;
				end
			end
			S_PMUL: begin
				cmd = '{op: DP_MUL, sel: MU_ACC_BASE};
				state_d = S_PMW;
			end
			S_PMW: if (stat.div_done) begin
				cmd = '{op: DP_WB, sel: WB_ACC};
				state_d = S_PSQR;
			end
			S_PSQR: begin
				cmd = '{op: DP_MUL, sel: MU_BASE_SQ};
				state_d = S_PSW;
			end
			S_PSW: if (stat.div_done) begin
				cmd = '{op: DP_WB, sel: WB_BASE};
				state_d = S_PSHF;
			end
			S_PSHF: begin
				cmd.op  = DP_SHIFT;
				state_d = S_PCHK;
			end
			S_XMUL: begin
				cmd.op = DP_MUL;
				case (ph_q)
					PH_O2:   cmd.sel = MU_MSG_ACC;
					PH_RED:  cmd.sel = MU_C1_ONE;
					default: cmd.sel = MU_C2_ACC;
				endcase
				state_d = S_XW;
			end
			S_XW: if (stat.div_done) begin
				cmd.op = DP_WB;
				case (ph_q)
					PH_O2:   begin cmd.sel = WB_O2; ph_d = PH_O1; state_d = S_PINIT; end
					PH_RED:  begin cmd.sel = WB_A;  state_d = S_EINIT; end
					default: begin cmd.sel = WB_REC; state_d = S_DONE; end
				endcase
			end
			S_EINIT: begin
				if (stat.p_lt2 || stat.r1_zero) begin
					cmd.op = DP_FAIL; state_d = S_DONE;
				end else begin
					cmd.op = DP_EINIT; state_d = S_ECHK;
				end
			end
			S_ECHK: begin
				if (stat.r1_zero) begin
					if (stat.r0_one) begin
						ph_d = PH_INV; state_d = S_PINIT;
					end else begin
						cmd.op = DP_FAIL; state_d = S_DONE;
					end
				end else begin
					state_d = S_EDIV;
				end
			end
			S_EDIV: begin
				cmd.op  = DP_EDIV;
				state_d = S_EDW;
			end
			S_EDW: if (stat.div_done) state_d = S_EMUL;
			S_EMUL: begin
				cmd.op  = DP_EMUL;
				state_d = S_EUPD;
			end
			S_EUPD: begin
				cmd.op  = DP_EUPD;
				state_d = S_ECHK;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_Y;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
endmodule
`default_nettype wire

[sv/elgamal_modexp_engine.sv]
// Top level of the ElGamal modular exponentiation engine: configuration
// registers, controller and datapath. Depends on emx_pkg, emx_ctrl and emx_dp.
//
// Channel        Ports                                  Beat
// command        start, busy, item                      start && !busy
// result         done, result                           done (one cycle)
// configuration  cfg_we, cfg_index, cfg_data            cfg_we
//
// One item is worked on at a time; busy stays high from the accepting edge
// through the cycle in which done is shown. Each modular multiply is one
// product feeding the shared divider, which retires four quotient bits a
// cycle; an exponent bit costs up to two multiplies. Encrypt runs three
// exponentiations; decrypt runs the Euclid loop and one exponentiation.
// Reset clears the controller and restores the register defaults. The
// receiver cannot stall: the result beat is there for exactly one cycle.
`default_nettype none
module elgamal_modexp_engine import emx_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire item_t        item,
	output logic              done,
	output result_t           result,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [W-1:0] cfg_data
);
	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Writes to an index beyond the three registers are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus     <= MODULUS_RST;
			cfg_q.generator   <= GENERATOR_RST;
			cfg_q.private_key <= PRIVATE_KEY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODULUS:     cfg_q.modulus     <= cfg_data;
				REG_GENERATOR:   cfg_q.generator   <= cfg_data;
				REG_PRIVATE_KEY: cfg_q.private_key <= cfg_data;
				default: ;
			endcase
		end
	end

	emx_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	emx_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.item   (item),
		.stat   (stat),
		.res    (result)
	);
endmodule
`default_nettype wire
